/* hw/rtl/jst_pkg.sv */
// ----------------------------------------------------------------------------
// jst_pkg: shared types and codes for the JSON stream tokenizer
// Holds transfer payload types, parser state, phase, event and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package jst_pkg;

  localparam int MAX_DEPTH = 64;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int STACK_AW  = $clog2(MAX_DEPTH);

  // parser phases
  localparam logic [4:0] PH_TOP       = 5'd0;
  localparam logic [4:0] PH_VALUE     = 5'd1;
  localparam logic [4:0] PH_ARR_FIRST = 5'd2;
  localparam logic [4:0] PH_OBJ_FIRST = 5'd3;
  localparam logic [4:0] PH_OBJ_KEY   = 5'd4;
  localparam logic [4:0] PH_KEY       = 5'd5;
  localparam logic [4:0] PH_KEY_ESC   = 5'd6;
  localparam logic [4:0] PH_KEY_HEX   = 5'd7;
  localparam logic [4:0] PH_COLON     = 5'd8;
  localparam logic [4:0] PH_AFTER     = 5'd9;
  localparam logic [4:0] PH_STR       = 5'd10;
  localparam logic [4:0] PH_STR_ESC   = 5'd11;
  localparam logic [4:0] PH_STR_HEX   = 5'd12;
  localparam logic [4:0] PH_NUM_MINUS = 5'd13;
  localparam logic [4:0] PH_NUM_ZERO  = 5'd14;
  localparam logic [4:0] PH_NUM_INT   = 5'd15;
  localparam logic [4:0] PH_NUM_DOT   = 5'd16;
  localparam logic [4:0] PH_NUM_FRAC  = 5'd17;
  localparam logic [4:0] PH_NUM_E     = 5'd18;
  localparam logic [4:0] PH_NUM_ESIGN = 5'd19;
  localparam logic [4:0] PH_NUM_EXP   = 5'd20;
  localparam logic [4:0] PH_LIT       = 5'd21;
  localparam logic [4:0] PH_DONE      = 5'd22;
  localparam logic [4:0] PH_ERR       = 5'd23;

  // token events
  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_OBJ_OPEN  = 4'd1;
  localparam logic [3:0] EV_OBJ_CLOSE = 4'd2;
  localparam logic [3:0] EV_ARR_OPEN  = 4'd3;
  localparam logic [3:0] EV_ARR_CLOSE = 4'd4;
  localparam logic [3:0] EV_KEY_BYTE  = 4'd5;
  localparam logic [3:0] EV_KEY_END   = 4'd6;
  localparam logic [3:0] EV_STR_BYTE  = 4'd7;
  localparam logic [3:0] EV_STR_END   = 4'd8;
  localparam logic [3:0] EV_NUM_BYTE  = 4'd9;
  localparam logic [3:0] EV_NUM_END   = 4'd10;

  // status codes
  localparam logic [3:0] STAT_OK        = 4'd0;
  localparam logic [3:0] STAT_NOT_VALUE = 4'd1;
  localparam logic [3:0] STAT_BAD_INPUT = 4'd2;
  localparam logic [3:0] STAT_COLON     = 4'd3;
  localparam logic [3:0] STAT_COMMA     = 4'd4;
  localparam logic [3:0] STAT_ESCAPE    = 4'd5;
  localparam logic [3:0] STAT_HEX       = 4'd6;
  localparam logic [3:0] STAT_DIGIT     = 4'd7;
  localparam logic [3:0] STAT_LITERAL   = 4'd8;
  localparam logic [3:0] STAT_CONTROL   = 4'd9;
  localparam logic [3:0] STAT_MORE      = 4'd10;
  localparam logic [3:0] STAT_TOO_DEEP  = 4'd11;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic [7:0] out_byte;
    logic [3:0] status;
    logic       doc_done;
    logic [6:0] level;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic [4:0]         phase;
    logic [DEPTH_W-1:0] depth;
    logic [1:0]         lit_kind;
    logic [2:0]         lit_pos;
    logic [2:0]         hex_left;
    logic [3:0]         err;
    logic               closed;
  } state_t;

  localparam state_t STATE_INIT = '0;

  // result of one byte through the parser, with its stack operation
  typedef struct packed {
    state_t     nxt;
    logic [1:0] n_res;
    out_t       res0;
    out_t       res1;
    logic       push;
    logic       pop;
    logic       push_obj;
  } step_t;

endpackage

`default_nettype wire

/* hw/rtl/jst_step.sv */
// ----------------------------------------------------------------------------
// jst_step: combinational parse of one byte
// Runs up to two parser passes on a byte and builds zero to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module jst_step import jst_pkg::*; (
  input  state_t     st,
  input  in_t        item,
  input  logic       top_bit,
  output step_t      step
);

  typedef struct packed {
    state_t     s;
    logic       emit;
    logic [3:0] ev;
    logic [7:0] byt;
    logic       redo;
    logic       push;
    logic       pop;
    logic       obj;
  } pass_t;

  function automatic logic is_ws(logic [7:0] b);
    return b inside {8'h20, 8'h09, 8'h0A, 8'h0D};
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_xdigit(logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  function automatic logic is_alnum(logic [7:0] b);
    return b inside {[8'h30:8'h39], [8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic [2:0] lit_len(logic [1:0] k);
    case (k)
      2'd1:    return 3'd4;
      2'd2:    return 3'd5;
      2'd3:    return 3'd4;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] k, logic [2:0] pos);
    logic [39:0] txt;
    txt = 40'h0;
    case (k)
      2'd1:    txt = {"true", 8'h00};
      2'd2:    txt = "false";
      2'd3:    txt = {"null", 8'h00};
      default: txt = 40'h0;
    endcase
    case (pos)
      3'd0:    return txt[39:32];
      3'd1:    return txt[31:24];
      3'd2:    return txt[23:16];
      3'd3:    return txt[15:8];
      3'd4:    return txt[7:0];
      default: return 8'h00;
    endcase
  endfunction

  function automatic pass_t f_emit(pass_t p, logic [3:0] ev, logic [7:0] b);
    p.emit = 1'b1;
    p.ev   = ev;
    p.byt  = b;
    return p;
  endfunction

  function automatic pass_t f_fail(pass_t p, logic [3:0] code);
    p.s.err   = code;
    p.s.phase = PH_ERR;
    return f_emit(p, EV_NONE, 8'h00);
  endfunction

  function automatic pass_t f_open(pass_t p, logic obj);
    if (p.s.depth >= DEPTH_W'(MAX_DEPTH)) begin
      return f_fail(p, STAT_TOO_DEEP);
    end
    p.push    = 1'b1;
    p.obj     = obj;
    p.s.depth = p.s.depth + DEPTH_W'(1);
    p.s.phase = obj ? PH_OBJ_FIRST : PH_ARR_FIRST;
    return f_emit(p, obj ? EV_OBJ_OPEN : EV_ARR_OPEN, 8'h00);
  endfunction

  function automatic pass_t f_close(pass_t p, logic obj);
    if (p.s.depth != '0) p.s.depth = p.s.depth - DEPTH_W'(1);
    p.pop = 1'b1;
    if (p.s.depth == '0) begin
      p.s.closed = 1'b1;
      p.s.phase  = PH_DONE;
    end else begin
      p.s.phase = PH_AFTER;
    end
    return f_emit(p, obj ? EV_OBJ_CLOSE : EV_ARR_CLOSE, 8'h00);
  endfunction

  function automatic pass_t f_start(pass_t p, logic [7:0] b);
    if (b == "{") return f_open(p, 1'b1);
    if (b == "[") return f_open(p, 1'b0);
    if (b == "\"") begin
      p.s.phase = PH_STR;
      return p;
    end
    if (b inside {"t", "f", "n"}) begin
      p.s.lit_kind = (b == "t") ? 2'd1 : (b == "f") ? 2'd2 : 2'd3;
      p.s.lit_pos  = 3'd1;
      p.s.phase    = PH_LIT;
      return p;
    end
    if (b == "-") begin
      p.s.phase = PH_NUM_MINUS;
      return f_emit(p, EV_NUM_BYTE, b);
    end
    if (b == "0") begin
      p.s.phase = PH_NUM_ZERO;
      return f_emit(p, EV_NUM_BYTE, b);
    end
    if (is_digit(b)) begin
      p.s.phase = PH_NUM_INT;
      return f_emit(p, EV_NUM_BYTE, b);
    end
    return f_fail(p, STAT_NOT_VALUE);
  endfunction

  function automatic pass_t f_end_num(pass_t p);
    p.s.phase = PH_AFTER;
    p.redo    = 1'b1;
    return f_emit(p, EV_NUM_END, 8'h00);
  endfunction

  function automatic pass_t f_str(pass_t p, logic [7:0] b, logic key);
    if (b == "\"") begin
      p.s.phase = key ? PH_COLON : PH_AFTER;
      return f_emit(p, key ? EV_KEY_END : EV_STR_END, 8'h00);
    end
    if (b == "\\") begin
      p.s.phase = key ? PH_KEY_ESC : PH_STR_ESC;
      return f_emit(p, key ? EV_KEY_BYTE : EV_STR_BYTE, b);
    end
    if (b inside {8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09}) return f_fail(p, STAT_CONTROL);
    return f_emit(p, key ? EV_KEY_BYTE : EV_STR_BYTE, b);
  endfunction

  function automatic pass_t f_esc(pass_t p, logic [7:0] b, logic key);
    if (b inside {"\"", "\\", "/", "b", "f", "n", "r", "t", "u"}) begin
      if (b == "u") begin
        p.s.hex_left = 3'd4;
        p.s.phase    = key ? PH_KEY_HEX : PH_STR_HEX;
      end else begin
        p.s.phase = key ? PH_KEY : PH_STR;
      end
      return f_emit(p, key ? EV_KEY_BYTE : EV_STR_BYTE, b);
    end
    return f_fail(p, STAT_ESCAPE);
  endfunction

  function automatic pass_t f_hex(pass_t p, logic [7:0] b, logic key);
    if (!is_xdigit(b)) return f_fail(p, STAT_HEX);
    if (p.s.hex_left != 3'd0) p.s.hex_left = p.s.hex_left - 3'd1;
    if (p.s.hex_left == 3'd0) p.s.phase = key ? PH_KEY : PH_STR;
    return f_emit(p, key ? EV_KEY_BYTE : EV_STR_BYTE, b);
  endfunction

  function automatic pass_t f_pass(state_t s, logic [7:0] b, logic tb);
    pass_t      p;
    logic       top_obj;
    logic [1:0] k;
    p       = '0;
    p.s     = s;
    top_obj = (s.depth != '0) && tb;
    k       = s.lit_kind;
    case (s.phase)
      PH_TOP: begin
        if (!is_ws(b)) begin
          if (b == "{") p = f_open(p, 1'b1);
          else if (b == "[") p = f_open(p, 1'b0);
          else p = f_fail(p, STAT_BAD_INPUT);
        end
      end
      PH_VALUE: begin
        if (!is_ws(b)) p = f_start(p, b);
      end
      PH_ARR_FIRST: begin
        if (!is_ws(b)) begin
          if (b == "]") p = f_close(p, 1'b0);
          else p = f_start(p, b);
        end
      end
      PH_OBJ_FIRST, PH_OBJ_KEY: begin
        if (!is_ws(b)) begin
          if (b == "}" && s.phase == PH_OBJ_FIRST) p = f_close(p, 1'b1);
          else if (b == "\"") p.s.phase = PH_KEY;
          else p = f_fail(p, STAT_NOT_VALUE);
        end
      end
      PH_KEY:     p = f_str(p, b, 1'b1);
      PH_KEY_ESC: p = f_esc(p, b, 1'b1);
      PH_KEY_HEX: p = f_hex(p, b, 1'b1);
      PH_STR:     p = f_str(p, b, 1'b0);
      PH_STR_ESC: p = f_esc(p, b, 1'b0);
      PH_STR_HEX: p = f_hex(p, b, 1'b0);
      PH_COLON: begin
        if (!is_ws(b)) begin
          if (b == ":") p.s.phase = PH_VALUE;
          else p = f_fail(p, STAT_COLON);
        end
      end
      PH_AFTER: begin
        if (!is_ws(b)) begin
          if (b == ",") p.s.phase = top_obj ? PH_OBJ_KEY : PH_VALUE;
          else if (b == "}" && top_obj) p = f_close(p, 1'b1);
          else if (b == "]" && !top_obj) p = f_close(p, 1'b0);
          else p = f_fail(p, STAT_COMMA);
        end
      end
      PH_NUM_MINUS: begin
        if (b == "0") begin
          p.s.phase = PH_NUM_ZERO;
          p = f_emit(p, EV_NUM_BYTE, b);
        end else if (is_digit(b)) begin
          p.s.phase = PH_NUM_INT;
          p = f_emit(p, EV_NUM_BYTE, b);
        end else begin
          p = f_fail(p, STAT_NOT_VALUE);
        end
      end
      PH_NUM_ZERO, PH_NUM_INT: begin
        if (is_digit(b) && s.phase == PH_NUM_INT) begin
          p = f_emit(p, EV_NUM_BYTE, b);
        end else if (b == ".") begin
          p.s.phase = PH_NUM_DOT;
          p = f_emit(p, EV_NUM_BYTE, b);
        end else if (b == "e" || b == "E") begin
          p.s.phase = PH_NUM_E;
          p = f_emit(p, EV_NUM_BYTE, b);
        end else begin
          p = f_end_num(p);
        end
      end
      PH_NUM_DOT: begin
        if (is_digit(b)) begin
          p.s.phase = PH_NUM_FRAC;
          p = f_emit(p, EV_NUM_BYTE, b);
        end else begin
          p = f_fail(p, STAT_DIGIT);
        end
      end
      PH_NUM_FRAC: begin
        if (is_digit(b)) begin
          p = f_emit(p, EV_NUM_BYTE, b);
        end else if (b == "e" || b == "E") begin
          p.s.phase = PH_NUM_E;
          p = f_emit(p, EV_NUM_BYTE, b);
        end else begin
          p = f_end_num(p);
        end
      end
      PH_NUM_E: begin
        if (b == "+" || b == "-") begin
          p.s.phase = PH_NUM_ESIGN;
          p = f_emit(p, EV_NUM_BYTE, b);
        end else if (is_digit(b)) begin
          p.s.phase = PH_NUM_EXP;
          p = f_emit(p, EV_NUM_BYTE, b);
        end else begin
          p = f_fail(p, STAT_DIGIT);
        end
      end
      PH_NUM_ESIGN: begin
        if (is_digit(b)) begin
          p.s.phase = PH_NUM_EXP;
          p = f_emit(p, EV_NUM_BYTE, b);
        end else begin
          p = f_fail(p, STAT_DIGIT);
        end
      end
      PH_NUM_EXP: begin
        if (is_digit(b)) p = f_emit(p, EV_NUM_BYTE, b);
        else p = f_end_num(p);
      end
      PH_LIT: begin
        if (k == 2'd0) begin
          p = f_fail(p, STAT_LITERAL);
        end else if (s.lit_pos < lit_len(k)) begin
          if (b == lit_char(k, s.lit_pos)) p.s.lit_pos = s.lit_pos + 3'd1;
          else p = f_fail(p, STAT_LITERAL);
        end else if (is_alnum(b)) begin
          p = f_fail(p, STAT_LITERAL);
        end else begin
          p.s.lit_kind = 2'd0;
          p.s.lit_pos  = 3'd0;
          p.s.phase    = PH_AFTER;
          p.redo       = 1'b1;
          p = f_emit(p, EV_NUM_END + {2'b00, k}, 8'h00);
        end
      end
      PH_DONE: begin
        if (!is_ws(b)) p = f_fail(p, STAT_MORE);
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic out_t mk_res(pass_t p);
    out_t r;
    r.event_res   = p.ev;
    r.out_byte    = p.byt;
    r.status      = p.s.err;
    r.doc_done    = p.s.closed;
    r.level       = 7'(p.s.depth);
    r.last_of_run = 1'b0;
    return r;
  endfunction

  pass_t      p1;
  pass_t      p2;
  logic       run1;
  logic       run2;
  state_t     fin;
  logic [3:0] verdict;
  out_t       r0;
  out_t       r1;
  logic [1:0] n;

  // first pass, then a second one when a number or literal ended on this byte
  always_comb begin
    run1 = (st.phase != PH_ERR);
    p1   = f_pass(st, item.in_byte, top_bit);
    run2 = run1 && p1.redo && (p1.s.phase != PH_ERR);
    p2   = f_pass(p1.s, item.in_byte, top_bit);
  end

  // collect results and apply end of document
  always_comb begin
    r0  = '0;
    r1  = '0;
    n   = 2'd0;
    fin = st;
    if (run1) begin
      fin = p1.s;
      if (p1.emit) begin
        r0 = mk_res(p1);
        n  = 2'd1;
      end
    end
    if (run2) begin
      fin = p2.s;
      if (p2.emit) begin
        if (n == 2'd0) r0 = mk_res(p2);
        else r1 = mk_res(p2);
        n = n + 2'd1;
      end
    end
    verdict = (fin.err != STAT_OK) ? fin.err :
              (fin.closed ? STAT_OK : STAT_BAD_INPUT);
    if (item.end_of_input) begin
      if (n == 2'd0) begin
        r0.event_res = EV_NONE;
        r0.out_byte  = 8'h00;
        r0.doc_done  = fin.closed;
        r0.level     = 7'(fin.depth);
        n            = 2'd1;
      end
      if (n == 2'd2) r1.status = verdict;
      else r0.status = verdict;
    end
    if (n == 2'd2) r1.last_of_run = 1'b1;
    else r0.last_of_run = 1'b1;
  end

  // pack step result
  always_comb begin
    step.nxt      = item.end_of_input ? STATE_INIT : fin;
    step.n_res    = n;
    step.res0     = r0;
    step.res1     = r1;
    step.push     = (run1 && p1.push) || (run2 && p2.push);
    step.pop      = (run1 && p1.pop) || (run2 && p2.pop);
    step.push_obj = (run1 && p1.push) ? p1.obj : p2.obj;
  end

endmodule

`default_nettype wire

/* hw/rtl/jst_res_buf.sv */
// ----------------------------------------------------------------------------
// jst_res_buf: two-entry result buffer
// Takes zero to two results per cycle and hands them out one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module jst_res_buf import jst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] wr_n,
  input  out_t       wr0,
  input  out_t       wr1,
  input  logic       rd,
  output out_t       head,
  output logic [1:0] cnt
);

  out_t       ent_r [2];
  out_t       ent_nxt [2];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [1:0] keep;

  // drop the head on a transfer, then append new results
  always_comb begin
    ent_nxt[0] = ent_r[0];
    ent_nxt[1] = ent_r[1];
    keep       = cnt_r;
    if (rd && cnt_r != 2'd0) begin
      ent_nxt[0] = ent_r[1];
      keep       = cnt_r - 2'd1;
    end
    if (wr_n != 2'd0) begin
      if (keep == 2'd0) begin
        ent_nxt[0] = wr0;
        ent_nxt[1] = wr1;
      end else begin
        ent_nxt[1] = wr0;
      end
    end
    cnt_nxt = keep + wr_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r[0] <= ent_nxt[0];
    ent_r[1] <= ent_nxt[1];
  end

  assign head = ent_r[0];
  assign cnt  = cnt_r;

endmodule

`default_nettype wire

/* hw/rtl/json_stream_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// json_stream_tokenizer_core: streaming JSON checker and tokenizer
// Validates JSON text a byte at a time and emits token events.
// ----------------------------------------------------------------------------
//  channel | direction | payload | handshake
//  in_     | input     | in_t    | in_valid / in_ready
//  out_    | output    | out_t   | out_valid / out_ready
//
//  One byte per cycle is taken while results drain at one per cycle; a byte
//  that causes two results (number or literal end plus its own event) leaves
//  one more result to drain. Path: input register, then the combinational
//  parse into the result buffer. The open-container stack is a 64-entry
//  memory with a registered read of the entry under the top. Reset clears
//  control state only. A stalled output holds at most two results and stops
//  the parse until room is free.
`default_nettype none

module json_stream_tokenizer_core import jst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic               in_valid_r;
  in_t                in_data_r;
  state_t             state_r;
  logic               top_r;
  logic               below_r;
  logic               stack_mem [MAX_DEPTH];
  step_t              step;
  logic [1:0]         buf_cnt;
  logic [2:0]         space;
  logic               go;
  logic               pop_out;
  logic [DEPTH_W-1:0] depth_nxt;
  logic [DEPTH_W-1:0] rd_full;

  // room left in the result buffer after this cycle's transfer
  assign pop_out  = out_ready && (buf_cnt != 2'd0);
  assign space    = 3'd2 - {1'b0, buf_cnt} + {2'b00, pop_out};
  assign go       = in_valid_r && ({1'b0, step.n_res} <= space);
  assign in_ready = !in_valid_r || go;

  // hold the input byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_data_r <= in_data;
    end
  end

  jst_step u_step (
    .st      (state_r),
    .item    (in_data_r),
    .top_bit (top_r),
    .step    (step)
  );

  // advance parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_INIT;
    end else if (go) begin
      state_r <= step.nxt;
    end
  end

  // track top of stack: push takes the new kind, pop takes the entry below
  always_ff @(posedge clk) begin
    if (go && step.push) begin
      top_r <= step.push_obj;
    end else if (go && step.pop) begin
      top_r <= below_r;
    end
  end

  // stack memory; read the entry below the next top each cycle
  assign depth_nxt = go ? step.nxt.depth : state_r.depth;
  assign rd_full   = depth_nxt - DEPTH_W'(2);

  always_ff @(posedge clk) begin
    if (go && step.push) begin
      stack_mem[state_r.depth[STACK_AW-1:0]] <= step.push_obj;
    end
    below_r <= stack_mem[rd_full[STACK_AW-1:0]];
  end

  jst_res_buf u_res_buf (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_n  (go ? step.n_res : 2'd0),
    .wr0   (step.res0),
    .wr1   (step.res1),
    .rd    (out_ready),
    .head  (out_data),
    .cnt   (buf_cnt)
  );

  assign out_valid = (buf_cnt != 2'd0);

  // checks
  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    buf_cnt != 2'd3) else $error("result buffer overfilled");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.depth <= DEPTH_W'(MAX_DEPTH)) else $error("nesting depth past limit");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    go && in_data_r.end_of_input |=> state_r.depth == '0 && state_r.phase == PH_TOP)
    else $error("state not reset after end of document");

  a_go_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> step.n_res != 2'd0 || !in_data_r.end_of_input)
    else $error("end of document produced no result");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the JSON stream tokenizer core
// Drives JSON text byte by byte, predicts token events and verdicts with a
// behavioral parser, and checks every result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import jst_pkg::*;

  localparam int LIMIT = 400000;

  // literal kinds of the predictor
  localparam int LK_NONE  = 0;
  localparam int LK_TRUE  = 1;
  localparam int LK_FALSE = 2;
  localparam int LK_NULL  = 3;

  // fixed expectations for the directed table
  localparam int CHK_PRED = 0;
  localparam int CHK_LAST = 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  always #2 clk = ~clk;

  json_stream_tokenizer_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor state
  logic [4:0] phase_q;
  logic       obj_stack [MAX_DEPTH];
  int         depth_q;
  int         lkind_q;
  int         lpos_q;
  int         hex_q;
  logic [3:0] err_q;
  logic       closed_q;
  out_t       step_res [2];
  int         step_n;
  logic       reprocess;

  out_t       expected_events [$];
  int         errors = 0;
  int         cycles = 0;
  int         send_idle = 30;
  int         recv_idle = 57;
  logic       hold_off = 1'b0;

  function automatic logic is_ws(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  function automatic logic is_dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_hex(logic [7:0] b);
    return is_dig(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic is_alnum(logic [7:0] b);
    return is_dig(b) || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic [7:0] lit_char(int k, int p);
    string s;
    s = (k == LK_TRUE) ? "true" : (k == LK_FALSE) ? "false" : "null";
    return s[p];
  endfunction

  function automatic int lit_len(int k);
    return (k == LK_FALSE) ? 5 : 4;
  endfunction

  task automatic clear_parser();
    phase_q = PH_TOP; depth_q = 0; lkind_q = LK_NONE; lpos_q = 0;
    hex_q = 0; err_q = STAT_OK; closed_q = 1'b0;
  endtask

  task automatic add_event(logic [3:0] ev, logic [7:0] b);
    if (step_n < 2) begin
      step_res[step_n] = '{event_res: ev, out_byte: b, status: err_q,
                           doc_done: closed_q, level: depth_q[6:0], last_of_run: 1'b0};
      step_n++;
    end
  endtask

  task automatic raise_error(logic [3:0] code);
    err_q = code;
    phase_q = PH_ERR;
    add_event(EV_NONE, 8'h00);
  endtask

  task automatic open_cont(logic obj);
    if (depth_q >= MAX_DEPTH) begin
      raise_error(STAT_TOO_DEEP);
    end else begin
      obj_stack[depth_q] = obj;
      depth_q++;
      add_event(obj ? EV_OBJ_OPEN : EV_ARR_OPEN, 8'h00);
      phase_q = obj ? PH_OBJ_FIRST : PH_ARR_FIRST;
    end
  endtask

  task automatic close_cont(logic obj);
    if (depth_q > 0) depth_q--;
    if (depth_q == 0) begin
      closed_q = 1'b1; phase_q = PH_DONE;
    end else begin
      phase_q = PH_AFTER;
    end
    add_event(obj ? EV_OBJ_CLOSE : EV_ARR_CLOSE, 8'h00);
  endtask

  task automatic begin_value(logic [7:0] b);
    if (b == "{") open_cont(1'b1);
    else if (b == "[") open_cont(1'b0);
    else if (b == "\"") phase_q = PH_STR;
    else if (b == "t" || b == "f" || b == "n") begin
      lkind_q = (b == "t") ? LK_TRUE : (b == "f") ? LK_FALSE : LK_NULL;
      lpos_q = 1; phase_q = PH_LIT;
    end else if (b == "-") begin
      add_event(EV_NUM_BYTE, b); phase_q = PH_NUM_MINUS;
    end else if (b == "0") begin
      add_event(EV_NUM_BYTE, b); phase_q = PH_NUM_ZERO;
    end else if (is_dig(b)) begin
      add_event(EV_NUM_BYTE, b); phase_q = PH_NUM_INT;
    end else raise_error(STAT_NOT_VALUE);
  endtask

  task automatic finish_number();
    add_event(EV_NUM_END, 8'h00);
    phase_q = PH_AFTER;
    reprocess = 1'b1;
  endtask

  task automatic text_byte(logic [7:0] b, logic key);
    logic [3:0] ev;
    ev = key ? EV_KEY_BYTE : EV_STR_BYTE;
    if (b == "\"") begin
      add_event(key ? EV_KEY_END : EV_STR_END, 8'h00);
      phase_q = key ? PH_COLON : PH_AFTER;
    end else if (b == "\\") begin
      add_event(ev, b); phase_q = key ? PH_KEY_ESC : PH_STR_ESC;
    end else if (b == 8'h08 || b == 8'h0C || b == 8'h0A || b == 8'h0D || b == 8'h09) begin
      raise_error(STAT_CONTROL);
    end else add_event(ev, b);
  endtask

  task automatic escape_byte(logic [7:0] b, logic key);
    if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
        b == "n" || b == "r" || b == "t" || b == "u") begin
      add_event(key ? EV_KEY_BYTE : EV_STR_BYTE, b);
      if (b == "u") begin
        hex_q = 4; phase_q = key ? PH_KEY_HEX : PH_STR_HEX;
      end else phase_q = key ? PH_KEY : PH_STR;
    end else raise_error(STAT_ESCAPE);
  endtask

  task automatic hex_byte(logic [7:0] b, logic key);
    if (!is_hex(b)) begin
      raise_error(STAT_HEX);
    end else begin
      add_event(key ? EV_KEY_BYTE : EV_STR_BYTE, b);
      if (hex_q > 0) hex_q--;
      if (hex_q == 0) phase_q = key ? PH_KEY : PH_STR;
    end
  endtask

  task automatic parse_byte(logic [7:0] b);
    logic top_obj;
    case (phase_q)
      PH_TOP: begin
        if (!is_ws(b)) begin
          if (b == "{") open_cont(1'b1);
          else if (b == "[") open_cont(1'b0);
          else raise_error(STAT_BAD_INPUT);
        end
      end
      PH_VALUE: if (!is_ws(b)) begin_value(b);
      PH_ARR_FIRST: begin
        if (!is_ws(b)) begin
          if (b == "]") close_cont(1'b0);
          else begin_value(b);
        end
      end
      PH_OBJ_FIRST, PH_OBJ_KEY: begin
        if (!is_ws(b)) begin
          if (b == "}" && phase_q == PH_OBJ_FIRST) close_cont(1'b1);
          else if (b == "\"") phase_q = PH_KEY;
          else raise_error(STAT_NOT_VALUE);
        end
      end
      PH_KEY:     text_byte(b, 1'b1);
      PH_KEY_ESC: escape_byte(b, 1'b1);
      PH_KEY_HEX: hex_byte(b, 1'b1);
      PH_STR:     text_byte(b, 1'b0);
      PH_STR_ESC: escape_byte(b, 1'b0);
      PH_STR_HEX: hex_byte(b, 1'b0);
      PH_COLON: begin
        if (!is_ws(b)) begin
          if (b == ":") phase_q = PH_VALUE;
          else raise_error(STAT_COLON);
        end
      end
      PH_AFTER: begin
        if (!is_ws(b)) begin
          top_obj = depth_q > 0 && obj_stack[depth_q - 1];
          if (b == ",") phase_q = top_obj ? PH_OBJ_KEY : PH_VALUE;
          else if (b == "}" && top_obj) close_cont(1'b1);
          else if (b == "]" && !top_obj) close_cont(1'b0);
          else raise_error(STAT_COMMA);
        end
      end
      PH_NUM_MINUS: begin
        if (b == "0") begin
          add_event(EV_NUM_BYTE, b); phase_q = PH_NUM_ZERO;
        end else if (is_dig(b)) begin
          add_event(EV_NUM_BYTE, b); phase_q = PH_NUM_INT;
        end else raise_error(STAT_NOT_VALUE);
      end
      PH_NUM_ZERO, PH_NUM_INT: begin
        if (is_dig(b) && phase_q == PH_NUM_INT) add_event(EV_NUM_BYTE, b);
        else if (b == ".") begin
          add_event(EV_NUM_BYTE, b); phase_q = PH_NUM_DOT;
        end else if (b == "e" || b == "E") begin
          add_event(EV_NUM_BYTE, b); phase_q = PH_NUM_E;
        end else finish_number();
      end
      PH_NUM_DOT: begin
        if (is_dig(b)) begin
          add_event(EV_NUM_BYTE, b); phase_q = PH_NUM_FRAC;
        end else raise_error(STAT_DIGIT);
      end
      PH_NUM_FRAC: begin
        if (is_dig(b)) add_event(EV_NUM_BYTE, b);
        else if (b == "e" || b == "E") begin
          add_event(EV_NUM_BYTE, b); phase_q = PH_NUM_E;
        end else finish_number();
      end
      PH_NUM_E: begin
        if (b == "+" || b == "-") begin
          add_event(EV_NUM_BYTE, b); phase_q = PH_NUM_ESIGN;
        end else if (is_dig(b)) begin
          add_event(EV_NUM_BYTE, b); phase_q = PH_NUM_EXP;
        end else raise_error(STAT_DIGIT);
      end
      PH_NUM_ESIGN: begin
        if (is_dig(b)) begin
          add_event(EV_NUM_BYTE, b); phase_q = PH_NUM_EXP;
        end else raise_error(STAT_DIGIT);
      end
      PH_NUM_EXP: begin
        if (is_dig(b)) add_event(EV_NUM_BYTE, b);
        else finish_number();
      end
      PH_LIT: begin
        if (lkind_q == LK_NONE) raise_error(STAT_LITERAL);
        else if (lpos_q < lit_len(lkind_q)) begin
          if (b == lit_char(lkind_q, lpos_q)) lpos_q++;
          else raise_error(STAT_LITERAL);
        end else if (is_alnum(b)) raise_error(STAT_LITERAL);
        else begin
          add_event(4'(10 + lkind_q), 8'h00);
          lkind_q = LK_NONE; lpos_q = 0; phase_q = PH_AFTER;
          reprocess = 1'b1;
        end
      end
      PH_DONE: if (!is_ws(b)) raise_error(STAT_MORE);
      default: ;
    endcase
  endtask

  // predict the results of one byte and queue them
  task automatic predict_tokens(in_t item);
    int passes;
    logic [3:0] verdict;
    step_n = 0; passes = 0; reprocess = 1'b1;
    while (reprocess && passes < 2 && phase_q != PH_ERR) begin
      reprocess = 1'b0;
      parse_byte(item.in_byte);
      passes++;
    end
    if (item.end_of_input) begin
      verdict = err_q;
      if (step_n == 0) add_event(EV_NONE, 8'h00);
      if (verdict == STAT_OK && !closed_q) verdict = STAT_BAD_INPUT;
      step_res[step_n - 1].status = verdict;
      clear_parser();
    end
    if (step_n > 0) step_res[step_n - 1].last_of_run = 1'b1;
    for (int i = 0; i < step_n; i++) expected_events.push_back(step_res[i]);
  endtask

  // offer one byte and hold until the transfer, then predict; valid stays
  // high into the next byte unless the sender idles or drains
  task automatic send_byte(logic [7:0] b, logic eoi);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{in_byte: b, end_of_input: eoi};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tokens('{in_byte: b, end_of_input: eoi});
  endtask

  task automatic send_text(string s, logic eoi);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eoi && i == s.len() - 1);
  endtask

  task automatic drain_events();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // random document: mostly well formed, with occasional corruption
  function automatic string rand_value(int lvl);
    string s, alph;
    int n;
    alph = "ab \\\"/u09AF.-e+";
    case ((lvl > 5) ? $urandom_range(3) : $urandom_range(5))
      0: begin
        s = ($urandom_range(1)) ? "-" : "";
        s = {s, $sformatf("%0d", $urandom_range(1200))};
        if ($urandom_range(1)) s = {s, ".", $sformatf("%0d", $urandom_range(99))};
        if ($urandom_range(2) == 0) s = {s, "e", ($urandom_range(1)) ? "-" : "+",
                                         $sformatf("%0d", $urandom_range(30))};
      end
      1: begin
        s = "\"";
        n = $urandom_range(6);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(5))
            0: s = {s, "\\n"};
            1: s = {s, "\\u0aF9"};
            default: s = {s, string'(8'($urandom_range(32, 255) == 92 ? 65 :
                                           $urandom_range(35, 255)))};
          endcase
        end
        s = {s, "\""};
      end
      2: s = ($urandom_range(2) == 0) ? "true" : ($urandom_range(1)) ? "false" : "null";
      3: s = ($urandom_range(1)) ? "[]" : "{ }";
      4: begin
        s = "[";
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) s = {s, (i ? ", " : ""), rand_value(lvl + 1)};
        s = {s, "]"};
      end
      default: begin
        s = "{";
        n = $urandom_range(3);
        for (int i = 0; i < n; i++)
          s = {s, (i ? "," : ""), "\"k", $sformatf("%0d", i), "\" : ", rand_value(lvl + 1)};
        s = {s, "}"};
      end
    endcase
    return s;
  endfunction

  task automatic send_random_doc(output int len);
    string s;
    int p;
    s = ($urandom_range(1)) ? rand_value(4) : rand_value(0);
    if (s[0] != "{" && s[0] != "[") s = {"[", s, "]"};
    if ($urandom_range(4) == 0) begin
      p = $urandom_range(s.len() - 1);
      s[p] = 8'($urandom_range(255));
    end
    if ($urandom_range(9) == 0) s = {s, " x"};
    s = {s, "\n"};
    len = s.len();
    send_text(s, 1'b1);
  endtask

  // directed table: text, check kind, fixed final status for CHK_LAST rows
  typedef struct {
    string      txt;
    int         chk;
    logic [3:0] verdict;
  } vec_t;

  vec_t vecs[$] = '{
    '{"{\"a\":[1,-0.5e+3,2E9,true,false,null,\"x\\u00fF\\n\"]}", CHK_LAST, STAT_OK},
    '{"x", CHK_LAST, STAT_BAD_INPUT},
    '{"  ", CHK_LAST, STAT_BAD_INPUT},
    '{"[1,]", CHK_LAST, STAT_NOT_VALUE},
    '{"[-a]", CHK_LAST, STAT_NOT_VALUE},
    '{"{1:2}", CHK_LAST, STAT_NOT_VALUE},
    '{"{\"a\" 1}", CHK_LAST, STAT_COLON},
    '{"[1}", CHK_LAST, STAT_COMMA},
    '{"[01]", CHK_LAST, STAT_COMMA},
    '{"[1.]", CHK_LAST, STAT_DIGIT},
    '{"[1e]", CHK_LAST, STAT_DIGIT},
    '{"[1e+]", CHK_LAST, STAT_DIGIT},
    '{"[tru]", CHK_LAST, STAT_LITERAL},
    '{"[truex]", CHK_LAST, STAT_LITERAL},
    '{"[\"\t\"]", CHK_LAST, STAT_CONTROL},
    '{"[\"\\q\"]", CHK_LAST, STAT_ESCAPE},
    '{"[\"\\u12g4\"]", CHK_LAST, STAT_HEX},
    '{"[] x", CHK_LAST, STAT_MORE},
    '{"[1", CHK_LAST, STAT_BAD_INPUT},
    '{"{ \"\\\"\\/\\b\\f\\r\\t\" :{}}", CHK_PRED, STAT_OK}
  };

  task automatic send_directed();
    out_t last;
    for (int v = 0; v < vecs.size(); v++) begin
      send_text(vecs[v].txt, 1'b1);
      if (vecs[v].chk == CHK_LAST) begin
        last = expected_events[expected_events.size() - 1];
        if (last.status != vecs[v].verdict) begin
          $display("%0t verdict row %0d: expected %0d actual %0d", $time, v,
                   vecs[v].verdict, last.status);
          errors++;
        end
      end
    end
    // byte extremes inside a string, then full-depth and one too deep
    send_byte("[", 1'b0); send_byte("\"", 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
    send_text("\"]", 1'b1);
    for (int i = 0; i < MAX_DEPTH; i++) send_byte("[", 1'b0);
    for (int i = 0; i < MAX_DEPTH; i++) send_byte("]", i == MAX_DEPTH - 1);
    for (int i = 0; i <= MAX_DEPTH; i++) send_byte("[", i == MAX_DEPTH);
    // noise bytes over all values
    for (int i = 0; i < 20; i++) send_byte(8'($urandom_range(255)), i == 19);
  endtask

  // receiver: random stalls or a long hold-off
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  // check every result transfer against the oldest expectation
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, out_data);
        errors++;
      end else begin
        exp_r = expected_events.pop_front();
        if (out_data.event_res != exp_r.event_res || out_data.out_byte != exp_r.out_byte ||
            out_data.status != exp_r.status || out_data.doc_done != exp_r.doc_done ||
            out_data.level != exp_r.level || out_data.last_of_run != exp_r.last_of_run) begin
          $display("%0t mismatch: expected ev=%0d b=%h st=%0d dn=%0b lv=%0d ls=%0b",
                   $time, exp_r.event_res, exp_r.out_byte, exp_r.status,
                   exp_r.doc_done, exp_r.level, exp_r.last_of_run);
          $display("%0t          actual ev=%0d b=%h st=%0d dn=%0b lv=%0d ls=%0b",
                   $time, out_data.event_res, out_data.out_byte, out_data.status,
                   out_data.doc_done, out_data.level, out_data.last_of_run);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("[json_stream_tokenizer_core] ERROR");
      $finish;
    end
  end

  int sent_bytes;
  int doc_len;

  initial begin
    clear_parser();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    // hold off the receiver while bytes keep coming
    hold_off <= 1'b1;
    fork
      send_text("[1,2,3,4,5,6,7,8,\"abcdefgh\"]", 1'b1);
      begin
        repeat (150) @(posedge clk);
        hold_off <= 1'b0;
      end
    join
    drain_events();
    // three idling phases of random documents
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 30 : (ph == 1) ? 57 : 0;
      recv_idle = (ph == 0) ? 57 : (ph == 1) ? 30 : 0;
      sent_bytes = 0;
      while (sent_bytes < 510) begin
        send_random_doc(doc_len);
        sent_bytes += doc_len;
      end
      drain_events();
    end
    if (errors == 0) begin
      $display("[json_stream_tokenizer_core] OK");
    end else begin
      $display("[json_stream_tokenizer_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
